// File: rtl/decaying_noise_burst_gen_defines.svh
// ---------------------------------------------------------------------------
// Decaying noise burst generator: assertion macros
// Shared property shorthands, clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef DECAYING_NOISE_BURST_GEN_DEFINES_SVH
`define DECAYING_NOISE_BURST_GEN_DEFINES_SVH

// Same-cycle implication.
`define DNBG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DNBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dnbg_pkg.sv
// ---------------------------------------------------------------------------
// dnbg_pkg
// Types, constants and register map of the decaying noise burst generator.
// ---------------------------------------------------------------------------
package dnbg_pkg;

    localparam int MAX_LENGTH_DEF = 16384;
    localparam int LEN_W          = 15;
    localparam int DECAY_W        = 24;
    localparam int COEF_W         = 16;
    localparam int ENV_W          = 25;
    localparam int SMP_W          = 24;   // filter memories and x, y
    localparam int OUT_W          = 16;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [31:0] SEED_BASE = 32'd12345;
    localparam logic [31:0] SEED_STEP = 32'd6789;
    localparam logic [31:0] LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] LCG_ADD   = 32'd12345;
    localparam logic [ENV_W-1:0] ENV_ONE = 25'd16777216;

    localparam logic [LEN_W-1:0]   LENGTH_RST = 15'd11025;
    localparam logic [DECAY_W-1:0] DECAY_RST  = 24'd16773411;
    localparam logic [COEF_W-1:0]  HPC_RST    = 16'd65163;
    localparam logic [COEF_W-1:0]  LPC_RST    = 16'd11857;

    typedef enum logic [1:0] {
        REG_LENGTH = 2'd0,
        REG_DECAY  = 2'd1,
        REG_HPC    = 2'd2,
        REG_LPC    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]   length_samples;
        logic [DECAY_W-1:0] decay_factor;
        logic [COEF_W-1:0]  highpass_coeff;
        logic [COEF_W-1:0]  lowpass_coeff;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RESTART,
        OP_MUL_SEED,
        OP_SEED_ADD,
        OP_MUL_X,
        OP_MUL_ENV,
        OP_MUL_HP,
        OP_HP_UPD,
        OP_MUL_LP,
        OP_LP_UPD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   channel;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_X_MUL,
        ST_ENV_MUL,
        ST_HP_MUL,
        ST_HP_UPD,
        ST_LP_MUL,
        ST_LP_UPD,
        ST_RESULT
    } ctrl_state_t;

endpackage

// File: rtl/dnbg_dp.sv
// ---------------------------------------------------------------------------
// dnbg_dp
// Datapath: LCG seed, envelope, two one-pole filters, one shared multiplier.
// ---------------------------------------------------------------------------
module dnbg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dnbg_pkg::dp_cmd_t                   cmd,
    input  dnbg_pkg::cfg_t                      cfg,
    output logic signed [dnbg_pkg::OUT_W-1:0]   sample
);
    import dnbg_pkg::*;

    logic [31:0]              seed_reg, seed_next;
    logic [ENV_W-1:0]         env_reg, env_next;
    logic signed [SMP_W-1:0]  x_reg, x_next;
    logic signed [SMP_W-1:0]  y_reg, y_next;
    logic signed [SMP_W-1:0]  hpm_reg, hpm_next;
    logic signed [SMP_W-1:0]  lpm_reg, lpm_next;
    logic signed [63:0]       prod_reg, prod_next;

    logic signed [31:0]       mul_a, mul_b;
    logic signed [63:0]       mul_p;
    logic signed [SMP_W-1:0]  noise;
    logic signed [SMP_W:0]    hp_diff, lp_diff, xh_diff;
    logic signed [SMP_W:0]    prod_sh16;
    logic signed [SMP_W:0]    hp_sum, lp_sum;
    logic signed [SMP_W-1:0]  y_calc;
    logic signed [SMP_W-8:0]  lpm_sh;

    // seed[31:8] - 2^23 is just the top bit flipped
    assign noise     = {~seed_reg[31], seed_reg[30:8]};
    assign hp_diff   = {hpm_reg[SMP_W-1], hpm_reg} - {x_reg[SMP_W-1], x_reg};
    assign xh_diff   = {x_reg[SMP_W-1], x_reg} - {hpm_reg[SMP_W-1], hpm_reg};
    assign y_calc    = xh_diff[SMP_W:1];
    assign lp_diff   = {lpm_reg[SMP_W-1], lpm_reg} - {y_calc[SMP_W-1], y_calc};
    assign prod_sh16 = prod_reg[SMP_W+16:16];
    assign hp_sum    = {x_reg[SMP_W-1], x_reg} + prod_sh16;
    assign lp_sum    = {y_reg[SMP_W-1], y_reg} + prod_sh16;
    assign mul_p     = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_SEED:
            begin
                mul_a = seed_reg;
                mul_b = LCG_MUL;
            end
            OP_MUL_X:
            begin
                mul_a = 32'(noise);
                mul_b = {7'd0, env_reg};
            end
            OP_MUL_ENV:
            begin
                mul_a = {7'd0, env_reg};
                mul_b = {8'd0, cfg.decay_factor};
            end
            OP_MUL_HP:
            begin
                mul_a = 32'(hp_diff);
                mul_b = {16'd0, cfg.highpass_coeff};
            end
            OP_MUL_LP:
            begin
                mul_a = 32'(lp_diff);
                mul_b = {16'd0, cfg.lowpass_coeff};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        seed_next = seed_reg;
        env_next  = env_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        hpm_next  = hpm_reg;
        lpm_next  = lpm_reg;
        prod_next = prod_reg;
        case (cmd.op)
            OP_RESTART:
            begin
                seed_next = cmd.channel ? (SEED_BASE + SEED_STEP) : SEED_BASE;
                env_next  = ENV_ONE;
            end
            OP_MUL_SEED:
            begin
                prod_next = mul_p;
            end
            OP_SEED_ADD:
            begin
                seed_next = prod_reg[31:0] + LCG_ADD;
            end
            OP_MUL_X:
            begin
                prod_next = mul_p;
            end
            OP_MUL_ENV:
            begin
                x_next    = prod_reg[SMP_W+23:24];
                prod_next = mul_p;
            end
            OP_MUL_HP:
            begin
                env_next  = prod_reg[ENV_W+23:24];
                prod_next = mul_p;
            end
            OP_HP_UPD:
            begin
                hpm_next = hp_sum[SMP_W-1:0];
            end
            OP_MUL_LP:
            begin
                y_next    = y_calc;
                prod_next = mul_p;
            end
            OP_LP_UPD:
            begin
                lpm_next = lp_sum[SMP_W-1:0];
            end
            default:
            begin
                seed_next = seed_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_BASE;
            env_reg  <= ENV_ONE;
            hpm_reg  <= '0;
            lpm_reg  <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
            env_reg  <= env_next;
            hpm_reg  <= hpm_next;
            lpm_reg  <= lpm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
    end

    // Q2.22 -> Q1.15 with saturation
    assign lpm_sh = lpm_reg[SMP_W-1:7];
    always_comb
    begin
        if (lpm_sh[SMP_W-8] != lpm_sh[SMP_W-9])
            sample = lpm_sh[SMP_W-8] ? 16'sh8000 : 16'sh7fff;
        else
            sample = lpm_sh[OUT_W-1:0];
    end

endmodule

// File: rtl/dnbg_ctrl.sv
// ---------------------------------------------------------------------------
// dnbg_ctrl
// Sequencer: burst index, per-sample step order and the output register.
// ---------------------------------------------------------------------------
module dnbg_ctrl #(
    parameter int MAX_LENGTH = dnbg_pkg::MAX_LENGTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               restart,
    input  logic                               channel,
    input  logic [dnbg_pkg::LEN_W-1:0]         length_samples,
    input  logic signed [dnbg_pkg::OUT_W-1:0]  dp_sample,
    output dnbg_pkg::dp_cmd_t                  cmd,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dnbg_pkg::OUT_W-1:0]         out_sample,
    output logic                               out_last
);
    import dnbg_pkg::*;

    localparam int MAX_W = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W = (MAX_W < LEN_W) ? MAX_W : LEN_W;
    localparam int CMP_W = (MAX_W > LEN_W) ? MAX_W : LEN_W;

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             silent_reg, silent_next;
    logic             oval_reg, oval_next;
    logic [OUT_W-1:0] osmp_reg, osmp_next;
    logic             olast_reg, olast_next;

    logic [CMP_W-1:0] len_wide, len_clamp;
    logic [IDX_W-1:0] len_eff;
    logic [IDX_W:0]   index_inc;
    logic             out_free;

    assign len_wide  = CMP_W'(length_samples);
    assign len_clamp = (len_wide > CMP_W'(MAX_LENGTH)) ? CMP_W'(MAX_LENGTH) : len_wide;
    assign len_eff   = len_clamp[IDX_W-1:0];
    assign index_inc = {1'b0, index_reg} + 1'b1;
    assign out_free  = !oval_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        index_next  = index_reg;
        silent_next = silent_reg;
        oval_next   = oval_reg && !out_ready;
        osmp_next   = osmp_reg;
        olast_next  = olast_reg;
        in_ready    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.channel = channel;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (restart)
                    begin
                        cmd.op      = OP_RESTART;
                        index_next  = '0;
                        silent_next = (len_eff == '0);
                    end
                    else
                    begin
                        silent_next = (index_reg >= len_eff);
                    end
                    state_next = (silent_next) ? ST_RESULT : ST_SEED_MUL;
                end
            end
            ST_SEED_MUL:
            begin
                cmd.op     = OP_MUL_SEED;
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD:
            begin
                cmd.op     = OP_SEED_ADD;
                state_next = ST_X_MUL;
            end
            ST_X_MUL:
            begin
                cmd.op     = OP_MUL_X;
                state_next = ST_ENV_MUL;
            end
            ST_ENV_MUL:
            begin
                cmd.op     = OP_MUL_ENV;
                state_next = ST_HP_MUL;
            end
            ST_HP_MUL:
            begin
                cmd.op     = OP_MUL_HP;
                state_next = ST_HP_UPD;
            end
            ST_HP_UPD:
            begin
                cmd.op     = OP_HP_UPD;
                state_next = ST_LP_MUL;
            end
            ST_LP_MUL:
            begin
                cmd.op     = OP_MUL_LP;
                state_next = ST_LP_UPD;
            end
            ST_LP_UPD:
            begin
                cmd.op     = OP_LP_UPD;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // wait here until the previous beat has left
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (silent_reg)
                    begin
                        osmp_next  = '0;
                        olast_next = 1'b0;
                    end
                    else
                    begin
                        osmp_next  = dp_sample;
                        olast_next = (index_inc == {1'b0, len_eff});
                        index_next = index_inc[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            index_reg  <= '0;
            silent_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            index_reg  <= index_next;
            silent_reg <= silent_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osmp_reg  <= osmp_next;
        olast_reg <= olast_next;
    end

    assign out_valid  = oval_reg;
    assign out_sample = osmp_reg;
    assign out_last   = olast_reg;

endmodule

// File: rtl/decaying_noise_burst_gen.sv
// A sample beat steps through the states SEED_MUL, SEED_ADD, X_MUL, ENV_MUL,
// HP_MUL, HP_UPD, LP_MUL, LP_UPD and RESULT before it appears; a beat past the
// end of the burst (zero sample) goes from IDLE straight to RESULT, which waits
// while the last output beat is not taken. A new item is accepted only once the
// last one is through; the single shared 32x32 multiplier is stepped by the sequencer through 5 products per sample.
// Reset: async active low; registers take their defaults, seed 12345,
// envelope 1.0, filters cleared, so a channel 0 burst is ready to run.
// ---------------------------------------------------------------------------
// decaying_noise_burst_gen
// LCG noise times decaying envelope, high-pass then low-pass, APB registers.
// ---------------------------------------------------------------------------
`include "decaying_noise_burst_gen_defines.svh"

module decaying_noise_burst_gen #(
    parameter int MAX_LENGTH = dnbg_pkg::MAX_LENGTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] channel
    input  logic                          s_tuser,   // [0] restart
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [15:0] sample
    output logic                          m_tlast,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dnbg_pkg::ADDR_W-1:0]   paddr,
    input  logic [dnbg_pkg::DATA_W-1:0]   pwdata,
    output logic [dnbg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import dnbg_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_sel;
    logic     wr_en;
    dp_cmd_t  cmd;
    logic signed [OUT_W-1:0] dp_sample;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_LENGTH: cfg_next.length_samples = pwdata[LEN_W-1:0];
                REG_DECAY:  cfg_next.decay_factor   = pwdata[DECAY_W-1:0];
                REG_HPC:    cfg_next.highpass_coeff = pwdata[COEF_W-1:0];
                REG_LPC:    cfg_next.lowpass_coeff  = pwdata[COEF_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LENGTH: prdata = DATA_W'(cfg_reg.length_samples);
            REG_DECAY:  prdata = DATA_W'(cfg_reg.decay_factor);
            REG_HPC:    prdata = DATA_W'(cfg_reg.highpass_coeff);
            REG_LPC:    prdata = DATA_W'(cfg_reg.lowpass_coeff);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length_samples <= LENGTH_RST;
            cfg_reg.decay_factor   <= DECAY_RST;
            cfg_reg.highpass_coeff <= HPC_RST;
            cfg_reg.lowpass_coeff  <= LPC_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dnbg_ctrl #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .restart        (s_tuser),
        .channel        (s_tdata[0]),
        .length_samples (cfg_reg.length_samples),
        .dp_sample      (dp_sample),
        .cmd            (cmd),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_sample     (m_tdata),
        .out_last       (m_tlast)
    );

    dnbg_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .sample (dp_sample)
    );

    // only one item is in work at a time
    `DNBG_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
        "input accepted while an item is still in work")
    `DNBG_ASSERT_NEXT(a_decay_write, wr_en && (reg_sel == REG_DECAY),
        cfg_reg.decay_factor == $past(pwdata[DECAY_W-1:0]),
        "decay register write lost")

endmodule

// File: sim/burst_sample_checker.sv
// ---------------------------------------------------------------------------
// burst_sample_checker
// Watches the register port and both streams of the decaying noise burst
// generator, predicts each output beat from its own copy of the registers
// and state, and compares every output beat against the oldest prediction.
// ---------------------------------------------------------------------------
module burst_sample_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] channel
    input  logic                        s_tuser,   // [0] restart
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,   // [15:0] sample
    input  logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dnbg_pkg::ADDR_W-1:0] paddr,
    input  logic [dnbg_pkg::DATA_W-1:0] pwdata,
    input  logic                        pready,
    output int                          errors,
    output int                          pending
);
    import dnbg_pkg::*;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
    } burst_beat_t;

    burst_beat_t expected_beats[$];

    // register copy
    logic [LEN_W-1:0]   len_r;
    logic [DECAY_W-1:0] decay_r;
    logic [COEF_W-1:0]  hpc_r;
    logic [COEF_W-1:0]  lpc_r;

    // generator state copy
    logic [31:0]              seed_q;
    logic [ENV_W-1:0]         env_q;
    logic [LEN_W-1:0]         idx_q;
    logic signed [SMP_W-1:0]  hp_q;
    logic signed [SMP_W-1:0]  lp_q;

    initial errors = 0;
    initial pending = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic burst_beat_t next_burst_sample(input logic restart, input logic channel);
        longint      noise;
        longint      x;
        longint      y;
        longint      s;
        longint      diff;
        int unsigned eff_len;
        burst_beat_t beat;
        eff_len = (len_r > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : len_r;
        if (restart)
        begin
            idx_q  = '0;
            env_q  = ENV_ONE;
            seed_q = SEED_BASE + (channel ? SEED_STEP : 32'd0);
        end
        beat.sample = '0;
        beat.last   = 1'b0;
        // past the end of the burst: silence, state frozen
        if (idx_q >= eff_len)
            return beat;
        seed_q = seed_q * LCG_MUL + LCG_ADD;
        noise  = longint'(seed_q[31:8]) - 64'sd8388608;
        x      = (noise * longint'(env_q)) >>> 24;
        env_q  = ENV_W'((longint'(env_q) * longint'(decay_r)) >> 24);
        diff   = longint'(hp_q) - x;
        hp_q   = SMP_W'(x + ((diff * longint'(hpc_r)) >>> 16));
        y      = (x - longint'(hp_q)) >>> 1;
        diff   = longint'(lp_q) - y;
        lp_q   = SMP_W'(y + ((diff * longint'(lpc_r)) >>> 16));
        s      = longint'(lp_q) >>> 7;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        beat.sample = s[15:0];
        beat.last   = (int'(idx_q) + 1 == eff_len);
        idx_q       = idx_q + 1'b1;
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        burst_beat_t exp_beat;
        if (!rst_n)
        begin
            len_r   = LENGTH_RST;
            decay_r = DECAY_RST;
            hpc_r   = HPC_RST;
            lpc_r   = LPC_RST;
            seed_q  = SEED_BASE;
            env_q   = ENV_ONE;
            idx_q   = '0;
            hp_q    = '0;
            lp_q    = '0;
            expected_beats.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_LENGTH: len_r   = pwdata[LEN_W-1:0];
                    REG_DECAY:  decay_r = pwdata[DECAY_W-1:0];
                    REG_HPC:    hpc_r   = pwdata[COEF_W-1:0];
                    REG_LPC:    lpc_r   = pwdata[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch($sformatf("unexpected beat sample=%h last=%b",
                        m_tdata, m_tlast));
                else
                begin
                    exp_beat = expected_beats.pop_front();
                    if (m_tdata !== exp_beat.sample)
                        report_mismatch($sformatf("sample got %h want %h",
                            m_tdata, exp_beat.sample));
                    if (m_tlast !== exp_beat.last)
                        report_mismatch($sformatf("last got %b want %b (sample %h)",
                            m_tlast, exp_beat.last, exp_beat.sample));
                end
            end
            if (s_tvalid && s_tready)
                expected_beats.insert(expected_beats.size(),
                    next_burst_sample(s_tuser, s_tdata[0]));
            pending = expected_beats.size();
        end
    end

endmodule

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives the decaying noise burst generator with directed and random bursts
// under several register settings, with random stalls on both streams, and
// reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb;
    import dnbg_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int TARGET_BEATS = 1450;
    localparam int SETTLE       = 14;
    localparam int LONG_HOLD    = 300;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [0] channel
    logic              s_tuser  = 1'b0; // [0] restart
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;         // [15:0] sample
    logic              m_tlast;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int errors;
    int pending;
    int cycles       = 0;
    int sent_beats   = 0;
    bit idle_en      = 1'b1;
    bit hold_request = 1'b0;

    always #5 clk = ~clk;

    decaying_noise_burst_gen dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    burst_sample_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sink side: random stalls, plus one long counted hold-off on request
    initial
    begin
        int hold_cnt;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < LONG_HOLD)
                begin
                    @(negedge clk);
                    hold_cnt++;
                end
                hold_request = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input logic restart, input logic channel);
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= {7'b0, channel};
        do
            @(posedge clk);
        while (!s_tready);
        sent_beats++;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int unsigned len, input int unsigned decay,
                              input int unsigned hpc, input int unsigned lpc);
        drain();
        write_reg(REG_LENGTH, len);
        write_reg(REG_DECAY, decay);
        write_reg(REG_HPC, hpc);
        write_reg(REG_LPC, lpc);
    endtask

    initial
    begin
        int unsigned len;
        int unsigned decay;
        int unsigned hpc;
        int unsigned lpc;
        int          phase;
        int          n_bursts;
        int          n_ticks;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset leaves a channel 0 burst armed: run it without a restart
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b0);

        // one-sample bursts, zero coefficients
        set_config(1, 0, 0, 0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b1);

        // zero length: all silence
        set_config(0, 32'h00FFFFFF, 32'h0000FFFF, 0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);

        // max coefficients, restart mid-burst
        set_config(3, 32'h00FFFFFF, 32'h0000FFFF, 32'h0000FFFF);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b1);
        send_beat(1'b0, 1'b0);
        send_beat(1'b0, 1'b0);

        // oversize length saturates; strong high-pass, no low-pass
        set_config(32'h00007FFF, 32'h00FFFFFF, 32'h0000FFFF, 0);
        send_beat(1'b1, 1'b0);
        send_beat(1'b0, 1'b0);
        set_config(MAX_LENGTH_DEF, 32'h00800000, 0, 32'h0000FFFF);
        send_beat(1'b1, 1'b1);
        send_beat(1'b0, 1'b1);

        phase = 0;
        while (sent_beats < TARGET_BEATS)
        begin
            case ($urandom_range(0, 11))
                0:       len = 0;
                1:       len = $urandom_range(MAX_LENGTH_DEF + 1, 32767);
                2:       len = MAX_LENGTH_DEF;
                default: len = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 5))
                0:       decay = 0;
                1:       decay = 32'h00FFFFFF;
                2:       decay = $urandom & 32'h00FFFFFF;
                default: decay = $urandom_range(32'h00E00000, 32'h00FFFFFF);
            endcase
            case ($urandom_range(0, 3))
                0:       hpc = 0;
                1:       hpc = 32'h0000FFFF;
                default: hpc = $urandom & 32'h0000FFFF;
            endcase
            case ($urandom_range(0, 3))
                0:       lpc = 0;
                1:       lpc = 32'h0000FFFF;
                default: lpc = $urandom & 32'h0000FFFF;
            endcase
            if (sent_beats > TARGET_BEATS - 150)
                idle_en = 1'b0;

            set_config(len, decay, hpc, lpc);
            // sender pause until all results are in happens inside set_config;
            // here the sink holds off once while the source keeps pushing
            if (phase == 3)
                hold_request = 1'b1;

            n_bursts = int'($urandom_range(1, 3));
            repeat (n_bursts)
            begin
                // occasionally run on without a restart
                send_beat($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
                n_ticks = int'((len > 40 || len == 0) ? $urandom_range(3, 30)
                                                      : len - 1 + $urandom_range(0, 2));
                repeat (n_ticks)
                begin
                    if ($urandom_range(0, 14) == 0)
                        send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    else
                        send_beat(1'b0, 1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end

        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
